// ===== rtl/mvm_pkg.sv =====
// ---------------------------------------------------------------------------
// mvm_pkg
// Shared sizes, codes and types of the matrix-vector multiply block.
// ---------------------------------------------------------------------------
package mvm_pkg;

   localparam int MAX_SIZE    = 1024;
   localparam int SAMPLE_BITS = 16;
   localparam int ADDR_BITS   = $clog2(MAX_SIZE);
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int ACC_BITS    = 48;
   localparam int INDEX_BITS  = 10;
   localparam int SIZE_BITS   = 11;
   localparam int KIND_BITS   = 2;

   localparam int REQ_DATA_BITS = ((INDEX_BITS + SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((INDEX_BITS + ACC_BITS + 7) / 8) * 8;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic CSR_SIZE_INDEX  = 1'b0;
   localparam logic CSR_ORDER_INDEX = 1'b1;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1024);

   localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_MATRIX = 2'd1,
      KIND_READ   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] size_in_use;
      logic                 column_order;
      logic [ADDR_BITS-1:0] last_pos;
      logic                 restart;
   } cfg_type;

   typedef struct packed {
      logic                   valid;
      kind_type               kind;
      logic [INDEX_BITS-1:0]  index;
      logic [SAMPLE_BITS-1:0] value;
      logic                   in_range;
      logic [ADDR_BITS-1:0]   row;
      logic [ADDR_BITS-1:0]   col;
      logic                   column_order;
      logic                   first_col;
      logic                   last_col;
      logic                   last_row;
   } cmd_type;

endpackage

// ===== rtl/matrix_vector_multiply.sv =====
// An accepted beat moves through the stage 1 and stage 2 registers, and its
// result is then captured in the output register.
// Throughput: one beat per cycle; the input stalls only while a new result
// meets a full output register that is not being taken.
// Reset clears the counters, accumulator, pipeline and output; the vector and
// result memories are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// matrix_vector_multiply
// Streaming y = A*x engine: vector load, row- or column-major matrix
// stream through a three-stage multiply-accumulate on two memories.
// ---------------------------------------------------------------------------
module matrix_vector_multiply (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // index [9:0], value [25:10], zero pad above
   input  logic [mvm_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // kind [1:0]
   input  logic [mvm_pkg::KIND_BITS-1:0]         req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // result_index [9:0], result_value [57:10], zero pad above
   output logic [mvm_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                  rsp_tlast,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mvm_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [mvm_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [mvm_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);

   mvm_pkg::cfg_type                 cfg;
   mvm_pkg::cmd_type                 cmd;
   logic                             advance;
   logic [mvm_pkg::INDEX_BITS-1:0]   out_index;
   logic [mvm_pkg::ACC_BITS-1:0]     out_value;

   mvm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mvm_position u_position (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .advance  (advance),
      .in_kind  (req_tuser),
      .in_index (req_tdata[mvm_pkg::INDEX_BITS-1:0]),
      .in_value (req_tdata[mvm_pkg::INDEX_BITS+mvm_pkg::SAMPLE_BITS-1:mvm_pkg::INDEX_BITS]),
      .cmd      (cmd)
   );

   mvm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_index (out_index),
      .out_value (out_value),
      .out_done  (rsp_tlast)
   );

   assign req_tready = advance;
   assign rsp_tdata  = mvm_pkg::RSP_DATA_BITS'({out_value, out_index});

endmodule

// ===== rtl/mvm_csr.sv =====
// ---------------------------------------------------------------------------
// mvm_csr
// APB-style register file holding the matrix size and the stream order.
// ---------------------------------------------------------------------------
module mvm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mvm_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mvm_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mvm_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output mvm_pkg::cfg_type                   cfg
);

   logic [mvm_pkg::SIZE_BITS-1:0] size_ff;
   logic [mvm_pkg::SIZE_BITS-1:0] size_in;
   logic                          order_ff;
   logic                          order_in;
   logic                          wr_en;
   logic                          reg_sel;
   logic [mvm_pkg::ADDR_BITS-1:0] last_pos;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      size_in  = size_ff;
      order_in = order_ff;
      if (wr_en) begin
         case (reg_sel)
            mvm_pkg::CSR_SIZE_INDEX: begin
               size_in = csr_pwdata[mvm_pkg::SIZE_BITS-1:0];
            end
            mvm_pkg::CSR_ORDER_INDEX: begin
               order_in = csr_pwdata[0];
            end
            default: begin
               size_in = size_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= mvm_pkg::SIZE_RESET;
         order_ff <= 1'b0;
      end else begin
         size_ff  <= size_in;
         order_ff <= order_in;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         last_pos = '0;
      end else if (32'(size_ff) > mvm_pkg::MAX_SIZE) begin
         last_pos = mvm_pkg::ADDR_BITS'(mvm_pkg::MAX_SIZE - 1);
      end else begin
         last_pos = mvm_pkg::ADDR_BITS'(size_ff - 1'b1);
      end
   end

   always_comb begin
      case (reg_sel)
         mvm_pkg::CSR_SIZE_INDEX: begin
            csr_prdata = mvm_pkg::CSR_DATA_BITS'(size_ff);
         end
         mvm_pkg::CSR_ORDER_INDEX: begin
            csr_prdata = mvm_pkg::CSR_DATA_BITS'(order_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign cfg.size_in_use  = size_ff;
   assign cfg.column_order = order_ff;
   assign cfg.last_pos     = last_pos;
   assign cfg.restart      = wr_en;

endmodule

// ===== rtl/mvm_position.sv =====
// ---------------------------------------------------------------------------
// mvm_position
// Row and column counters that place each streamed matrix element.
// ---------------------------------------------------------------------------
module mvm_position (
   input  logic                              clock,
   input  logic                              reset,
   input  mvm_pkg::cfg_type                  cfg,
   input  logic                              in_valid,
   input  logic                              advance,
   input  logic [mvm_pkg::KIND_BITS-1:0]     in_kind,
   input  logic [mvm_pkg::INDEX_BITS-1:0]    in_index,
   input  logic [mvm_pkg::SAMPLE_BITS-1:0]   in_value,
   output mvm_pkg::cmd_type                  cmd
);

   logic [mvm_pkg::ADDR_BITS-1:0] row_ff;
   logic [mvm_pkg::ADDR_BITS-1:0] row_in;
   logic [mvm_pkg::ADDR_BITS-1:0] col_ff;
   logic [mvm_pkg::ADDR_BITS-1:0] col_in;
   logic [mvm_pkg::ADDR_BITS-1:0] row_cur;
   logic [mvm_pkg::ADDR_BITS-1:0] col_cur;
   logic                          wrap;
   logic                          row_last;
   logic                          col_last;
   mvm_pkg::kind_type             kind;

   assign kind     = mvm_pkg::kind_type'(in_kind);
   assign wrap     = (row_ff > cfg.last_pos) || (col_ff > cfg.last_pos);
   assign row_cur  = wrap ? '0 : row_ff;
   assign col_cur  = wrap ? '0 : col_ff;
   assign row_last = (row_cur == cfg.last_pos);
   assign col_last = (col_cur == cfg.last_pos);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (cfg.restart) begin
         row_in = '0;
         col_in = '0;
      end else if (in_valid && advance && kind == mvm_pkg::KIND_MATRIX) begin
         if (cfg.column_order) begin
            row_in = row_last ? '0 : row_cur + 1'b1;
            col_in = row_last ? (col_last ? '0 : col_cur + 1'b1) : col_cur;
         end else begin
            col_in = col_last ? '0 : col_cur + 1'b1;
            row_in = col_last ? (row_last ? '0 : row_cur + 1'b1) : row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   assign cmd.valid        = in_valid;
   assign cmd.kind         = kind;
   assign cmd.index        = in_index;
   assign cmd.value        = in_value;
   assign cmd.in_range     = (32'(in_index) < mvm_pkg::MAX_SIZE);
   assign cmd.row          = row_cur;
   assign cmd.col          = col_cur;
   assign cmd.column_order = cfg.column_order;
   assign cmd.first_col    = (col_cur == '0);
   assign cmd.last_col     = col_last;
   assign cmd.last_row     = row_last;

endmodule

// ===== rtl/mvm_datapath.sv =====
// ---------------------------------------------------------------------------
// mvm_datapath
// Vector and result memories, multiply-accumulate pipeline with write
// forwarding, and the result output register.
// ---------------------------------------------------------------------------
module mvm_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mvm_pkg::cfg_type                  cfg,
   input  mvm_pkg::cmd_type                  cmd,
   output logic                              advance,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [mvm_pkg::INDEX_BITS-1:0]    out_index,
   output logic [mvm_pkg::ACC_BITS-1:0]      out_value,
   output logic                              out_done
);

   typedef struct packed {
      logic                          valid;
      mvm_pkg::kind_type             kind;
      logic [mvm_pkg::INDEX_BITS-1:0] index;
      logic                          in_range;
      logic [mvm_pkg::ADDR_BITS-1:0] row;
      logic [mvm_pkg::ADDR_BITS-1:0] res_addr;
      logic                          column_order;
      logic                          first_col;
      logic                          last_col;
      logic                          last_row;
   } stage_type;

   logic [mvm_pkg::SAMPLE_BITS-1:0] vec_mem [mvm_pkg::MAX_SIZE];
   logic [mvm_pkg::ACC_BITS-1:0]    res_mem [mvm_pkg::MAX_SIZE];

   logic [mvm_pkg::SAMPLE_BITS-1:0] vec_rd_ff;
   logic [mvm_pkg::ACC_BITS-1:0]    res_rd_ff;
   logic [mvm_pkg::SAMPLE_BITS-1:0] s1_value_ff;
   stage_type                       s0;
   stage_type                       s1_ff;
   stage_type                       s2_ff;
   logic [mvm_pkg::PROD_BITS-1:0]   prod_ff;
   logic [mvm_pkg::ACC_BITS-1:0]    old2_ff;
   logic [mvm_pkg::ACC_BITS-1:0]    acc_ff;
   logic [mvm_pkg::ACC_BITS-1:0]    acc_in;
   logic                            lw_valid_ff;
   logic [mvm_pkg::ADDR_BITS-1:0]   lw_addr_ff;
   logic [mvm_pkg::ACC_BITS-1:0]    lw_data_ff;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   logic [mvm_pkg::INDEX_BITS-1:0]  out_index_ff;
   logic [mvm_pkg::ACC_BITS-1:0]    out_value_ff;
   logic                            out_done_ff;

   logic [mvm_pkg::ADDR_BITS-1:0]   idx_addr;
   logic signed [mvm_pkg::PROD_BITS-1:0] prod;
   logic [mvm_pkg::ACC_BITS-1:0]    old1;
   logic [mvm_pkg::ACC_BITS-1:0]    old2;
   logic [mvm_pkg::ACC_BITS-1:0]    prod_ext;
   logic [mvm_pkg::ACC_BITS-1:0]    base;
   logic [mvm_pkg::ACC_BITS:0]      sum_wide;
   logic [mvm_pkg::ACC_BITS-1:0]    sum_sat;
   logic [mvm_pkg::ACC_BITS-1:0]    sum;
   logic                            is_matrix;
   logic                            is_read;
   logic                            produce;
   logic                            res_wen;
   logic [mvm_pkg::INDEX_BITS-1:0]  res_index;
   logic [mvm_pkg::ACC_BITS-1:0]    res_value;
   logic                            res_done;

   // Stage 0: decode the accepted beat and issue the memory reads.
   assign idx_addr = mvm_pkg::ADDR_BITS'(cmd.index);

   always_comb begin
      s0.valid        = cmd.valid;
      s0.kind         = cmd.kind;
      s0.index        = cmd.index;
      s0.in_range     = cmd.in_range;
      s0.row          = cmd.row;
      s0.res_addr     = (cmd.kind == mvm_pkg::KIND_READ) ? idx_addr : cmd.row;
      s0.column_order = cmd.column_order;
      s0.first_col    = cmd.first_col;
      s0.last_col     = cmd.last_col;
      s0.last_row     = cmd.last_row;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (cmd.valid && cmd.kind == mvm_pkg::KIND_LOAD && cmd.in_range) begin
            vec_mem[idx_addr] <= cmd.value;
         end
         vec_rd_ff   <= vec_mem[cmd.col];
         res_rd_ff   <= res_mem[s0.res_addr];
         s1_value_ff <= cmd.value;
      end
   end

   // Stage 1: multiply and merge the write retired two slots ahead.
   assign prod = $signed(s1_value_ff) * $signed(vec_rd_ff);
   assign old1 = (lw_valid_ff && lw_addr_ff == s1_ff.res_addr) ? lw_data_ff : res_rd_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod;
         old2_ff <= old1;
      end
   end

   // Stage 2: accumulate with saturation, write back and emit.
   assign old2     = (lw_valid_ff && lw_addr_ff == s2_ff.res_addr) ? lw_data_ff : old2_ff;
   assign prod_ext = {{(mvm_pkg::ACC_BITS-mvm_pkg::PROD_BITS){prod_ff[mvm_pkg::PROD_BITS-1]}},
                      prod_ff};
   assign base     = s2_ff.column_order ? old2 : acc_ff;
   assign sum_wide = {base[mvm_pkg::ACC_BITS-1], base}
                   + {prod_ext[mvm_pkg::ACC_BITS-1], prod_ext};

   always_comb begin
      if (sum_wide[mvm_pkg::ACC_BITS] != sum_wide[mvm_pkg::ACC_BITS-1]) begin
         sum_sat = sum_wide[mvm_pkg::ACC_BITS] ? mvm_pkg::ACC_MIN : mvm_pkg::ACC_MAX;
      end else begin
         sum_sat = sum_wide[mvm_pkg::ACC_BITS-1:0];
      end
   end

   assign sum       = s2_ff.first_col ? prod_ext : sum_sat;
   assign is_matrix = s2_ff.valid && s2_ff.kind == mvm_pkg::KIND_MATRIX;
   assign is_read   = s2_ff.valid && s2_ff.kind == mvm_pkg::KIND_READ;
   assign produce   = (is_matrix && s2_ff.last_col) || is_read;
   assign res_wen   = is_matrix && (s2_ff.column_order || s2_ff.last_col);
   assign advance   = !(produce && out_valid_ff && !out_ready);

   always_comb begin
      if (is_read) begin
         res_index = s2_ff.index;
         res_value = s2_ff.in_range ? old2 : '0;
         res_done  = 1'b0;
      end else begin
         res_index = mvm_pkg::INDEX_BITS'(s2_ff.row);
         res_value = sum;
         res_done  = s2_ff.last_row;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cfg.restart) begin
         acc_in = '0;
      end else if (advance && is_matrix && !s2_ff.column_order) begin
         acc_in = s2_ff.last_col ? '0 : sum;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && produce) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_wen) begin
         res_mem[s2_ff.res_addr] <= sum;
      end
      if (advance) begin
         lw_addr_ff <= s2_ff.res_addr;
         lw_data_ff <= sum;
      end
      if (advance && produce) begin
         out_index_ff <= res_index;
         out_value_ff <= res_value;
         out_done_ff  <= res_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         s2_ff        <= '0;
         lw_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_ff       <= s0;
            s2_ff       <= s1_ff;
            lw_valid_ff <= res_wen;
         end
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_index = out_index_ff;
   assign out_value = out_value_ff;
   assign out_done  = out_done_ff;

endmodule

// ===== tb/tb_matrix_vector_multiply.sv =====
// ---------------------------------------------------------------------------
// tb_matrix_vector_multiply
// Self-checking bench for the streaming matrix-vector multiply engine. A
// queue-fed driver sends vector loads, matrix elements and result reads,
// while a monitor checks every result beat against a predictor of y = A*x.
// The bench covers row and column order, small sizes, an oversized setting,
// random gaps on both sides and one long output stall.
// ---------------------------------------------------------------------------
module tb_matrix_vector_multiply;
   import mvm_pkg::*;

   localparam logic [KIND_BITS-1:0]     KIND_IGNORED = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] SIZE_ADDR    = {CSR_SIZE_INDEX, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ORDER_ADDR   = {CSR_ORDER_INDEX, 2'b00};
   localparam int     DRAIN_CYCLES = 8;
   localparam int     HOLD_CYCLES  = 80;
   localparam int     STALL_LIMIT  = 2000;
   localparam int     RANDOM_ITEMS = 640;
   localparam int     LOAD_SPAN    = 16;
   localparam int     READ_SPAN    = 24;
   localparam longint Y_MAX = longint'({16'b0, ACC_MAX});
   localparam longint Y_MIN = longint'($signed(ACC_MIN));

   typedef struct {
      logic [KIND_BITS-1:0]   kind;
      logic [INDEX_BITS-1:0]  index;
      logic [SAMPLE_BITS-1:0] value;
   } req_item_type;

   typedef struct {
      logic [INDEX_BITS-1:0] index;
      logic [ACC_BITS-1:0]   value;
      logic                  last;
   } y_beat_type;

   typedef enum int {
      GAPS_RX_HEAVY,
      GAPS_TX_HEAVY,
      GAPS_NONE
   } gap_mode_type;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_tvalid  = 1'b0;
   logic                       req_tready;
   // index [9:0], value [25:10], zero pad above
   logic [REQ_DATA_BITS-1:0]   req_tdata   = '0;
   // kind [1:0]
   logic [KIND_BITS-1:0]       req_tuser   = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready  = 1'b0;
   // result_index [9:0], result_value [57:10], zero pad above
   logic [RSP_DATA_BITS-1:0]   rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0]   csr_prdata;
   logic                       csr_pready;

   req_item_type req_queue [$];
   y_beat_type   pending_y [$];
   gap_mode_type gap_mode     = GAPS_RX_HEAVY;
   int           beats_queued = 0;
   int           beats_taken  = 0;
   int           mismatches   = 0;
   int           stall_cycles = 0;
   logic         hold_request = 1'b0;
   logic         hold_taken   = 1'b0;
   int           hold_left    = 0;

   logic [SAMPLE_BITS-1:0] x_model [MAX_SIZE];
   longint                 y_model [MAX_SIZE];
   longint                 acc_model  = 0;
   int                     row_model  = 0;
   int                     col_model  = 0;
   logic [SIZE_BITS-1:0]   size_model = SIZE_RESET;
   logic                   order_model = 1'b0;

   matrix_vector_multiply uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic roll(input int percent);
      return $urandom_range(0, 99) < percent;
   endfunction

   function automatic longint saturate_y(input longint sum);
      if (sum > Y_MAX) return Y_MAX;
      if (sum < Y_MIN) return Y_MIN;
      return sum;
   endfunction

   function automatic int effective_size(input logic [SIZE_BITS-1:0] size);
      if (size == 0) return 1;
      if (size > MAX_SIZE) return MAX_SIZE;
      return int'(size);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_value();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic compute_y_beat(input logic [KIND_BITS-1:0] kind,
                                 input logic [INDEX_BITS-1:0] index,
                                 input logic [SAMPLE_BITS-1:0] value);
      int     n;
      int     i;
      int     j;
      longint product;
      n = effective_size(size_model);
      case (kind)
         KIND_LOAD: begin
            x_model[index] = value;
         end
         KIND_READ: begin
            pending_y.push_back(y_beat_type'{index, ACC_BITS'(y_model[index]), 1'b0});
         end
         KIND_MATRIX: begin
            if (row_model >= n || col_model >= n) begin
               acc_model = 0;
               row_model = 0;
               col_model = 0;
            end
            i = row_model;
            j = col_model;
            product = longint'($signed(value)) * longint'($signed(x_model[j]));
            if (!order_model) begin
               acc_model = saturate_y((j == 0 ? 0 : acc_model) + product);
               if (j == n - 1) begin
                  y_model[i] = acc_model;
                  pending_y.push_back(y_beat_type'{INDEX_BITS'(i), ACC_BITS'(acc_model),
                                                   i == n - 1});
                  acc_model = 0;
               end
               col_model = j + 1;
               if (col_model >= n) begin
                  col_model = 0;
                  row_model = (i + 1 >= n) ? 0 : i + 1;
               end
            end else begin
               y_model[i] = saturate_y((j == 0 ? 0 : y_model[i]) + product);
               if (j == n - 1) begin
                  pending_y.push_back(y_beat_type'{INDEX_BITS'(i), ACC_BITS'(y_model[i]),
                                                   i == n - 1});
               end
               row_model = i + 1;
               if (row_model >= n) begin
                  row_model = 0;
                  col_model = (j + 1 >= n) ? 0 : j + 1;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("error: %s: got %0h, expected %0h", what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin : drive_requests
      req_item_type item;
      int           percent;
      percent = (gap_mode == GAPS_RX_HEAVY) ? 13 : (gap_mode == GAPS_TX_HEAVY) ? 74 : 0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_queue.size() != 0 && !roll(percent)) begin
            item = req_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= REQ_DATA_BITS'({item.value, item.index});
            req_tuser  <= item.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : accept_results
      int percent;
      percent = (gap_mode == GAPS_RX_HEAVY) ? 74 : (gap_mode == GAPS_TX_HEAVY) ? 13 : 0;
      if (hold_request != hold_taken) begin
         hold_taken <= hold_request;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !roll(percent);
      end
   end

   always @(posedge clock) begin : check_beats
      y_beat_type want;
      logic       progress;
      if (!reset) begin
         progress = 1'b0;
         if (req_tvalid && req_tready) begin
            compute_y_beat(req_tuser, req_tdata[INDEX_BITS-1:0],
                           req_tdata[INDEX_BITS +: SAMPLE_BITS]);
            beats_taken++;
            progress = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            progress = 1'b1;
            if (pending_y.size() == 0) begin
               report_mismatch("result beat with none expected", 64'(rsp_tdata), 64'd0);
            end else begin
               want = pending_y.pop_front();
               if (rsp_tdata[INDEX_BITS-1:0] !== want.index) begin
                  report_mismatch("result_index", 64'(rsp_tdata[INDEX_BITS-1:0]),
                                  64'(want.index));
               end
               if (rsp_tdata[INDEX_BITS +: ACC_BITS] !== want.value) begin
                  report_mismatch("result_value", 64'(rsp_tdata[INDEX_BITS +: ACC_BITS]),
                                  64'(want.value));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch("pass_done", 64'(rsp_tlast), 64'(want.last));
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            progress = 1'b1;
         end
         stall_cycles = progress ? 0 : stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("matrix_vector_multiply: mismatch");
            $finish;
         end
      end
   end

   task automatic push_item(input logic [KIND_BITS-1:0] kind,
                            input logic [INDEX_BITS-1:0] index,
                            input logic [SAMPLE_BITS-1:0] value);
      req_queue.push_back(req_item_type'{kind, index, value});
      beats_queued++;
   endtask

   task automatic write_csr(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // A register write restarts the pass; the two stores keep their contents.
   task automatic configure(input logic [SIZE_BITS-1:0] size, input logic order);
      write_csr(SIZE_ADDR, CSR_DATA_BITS'(size));
      write_csr(ORDER_ADDR, CSR_DATA_BITS'(order));
      size_model  = size;
      order_model = order;
      acc_model   = 0;
      row_model   = 0;
      col_model   = 0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (beats_taken != beats_queued || pending_y.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Reads stay within the result entries that have already been written.
   task automatic push_noise(inout int items_done);
      case ($urandom_range(0, 2))
         0: push_item(KIND_LOAD, INDEX_BITS'($urandom), random_value());
         1: push_item(KIND_READ, INDEX_BITS'($urandom_range(0, READ_SPAN - 1)),
                      random_value());
         default: push_item(KIND_IGNORED, INDEX_BITS'($urandom), random_value());
      endcase
      if (req_queue[$].kind != KIND_IGNORED) items_done++;
   endtask

   task automatic run_random_phase(inout int items_done);
      int                   n;
      int                   elements;
      int                   k;
      logic                 drain_mid;
      logic [SIZE_BITS-1:0] size;
      size = ($urandom_range(0, 7) == 0) ? SIZE_BITS'($urandom_range(7, 12))
                                         : SIZE_BITS'($urandom_range(1, 6));
      n = int'(size);
      configure(size, 1'($urandom_range(0, 1)));
      elements  = n * n + $urandom_range(0, n * n);
      drain_mid = ($urandom_range(0, 3) == 0);
      for (k = 0; k < elements; k++) begin
         while (roll(15)) push_noise(items_done);
         push_item(KIND_MATRIX, INDEX_BITS'($urandom), random_value());
         items_done++;
         if (drain_mid && k == elements / 2) wait_drained();
      end
      wait_drained();
   endtask

   initial begin : stimulus
      int items_done;
      int k;
      items_done = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Size one, row order: every element closes a pass; extreme products.
      configure(1, 1'b0);
      push_item(KIND_LOAD, 0, 16'h8000);
      push_item(KIND_MATRIX, 0, 16'h8000);
      push_item(KIND_MATRIX, 10'h3ff, 16'h7fff);
      push_item(KIND_READ, 0, 16'h0000);
      push_item(KIND_IGNORED, 10'h3ff, 16'hffff);
      push_item(KIND_LOAD, 10'h3ff, 16'h7fff);
      push_item(KIND_LOAD, 0, 16'h7fff);
      push_item(KIND_MATRIX, 0, 16'h7fff);
      push_item(KIND_MATRIX, 0, 16'h0000);
      push_item(KIND_READ, 0, 16'hffff);
      wait_drained();

      configure(2, 1'b1);
      push_item(KIND_LOAD, 1, 16'h8000);
      push_item(KIND_MATRIX, 0, 16'h8000);
      push_item(KIND_MATRIX, 0, 16'h7fff);
      push_item(KIND_MATRIX, 0, 16'h0001);
      push_item(KIND_MATRIX, 0, 16'hffff);
      push_item(KIND_READ, 1, 16'h0000);
      wait_drained();

      // A size of zero acts as one.
      configure(0, 1'b0);
      push_item(KIND_MATRIX, 0, 16'h4000);
      push_item(KIND_MATRIX, 0, 16'hc000);
      push_item(KIND_READ, 0, 16'h0000);
      wait_drained();

      // An oversized setting acts as the full size, so no row closes here; the
      // first column writes every y entry that the later reads may touch.
      configure(SIZE_BITS'(2047), 1'b1);
      for (k = 0; k < LOAD_SPAN; k++) push_item(KIND_LOAD, INDEX_BITS'(k), random_value());
      for (k = 0; k < READ_SPAN; k++) begin
         push_item(KIND_MATRIX, INDEX_BITS'($urandom), random_value());
      end
      push_item(KIND_READ, INDEX_BITS'(READ_SPAN - 1), 16'h0000);
      push_item(KIND_READ, INDEX_BITS'(LOAD_SPAN - 1), 16'hffff);
      wait_drained();

      while (items_done < RANDOM_ITEMS) begin
         gap_mode = (items_done < RANDOM_ITEMS / 3)     ? GAPS_RX_HEAVY :
                    (items_done < 2 * RANDOM_ITEMS / 3) ? GAPS_TX_HEAVY : GAPS_NONE;
         run_random_phase(items_done);
      end

      // Long output stall while the sender keeps offering beats.
      gap_mode = GAPS_NONE;
      configure(1, 1'b0);
      @(posedge clock);
      hold_request <= ~hold_request;
      for (k = 0; k < 40; k++) push_item(KIND_MATRIX, INDEX_BITS'($urandom), random_value());
      wait_drained();

      if (mismatches == 0) begin
         $display("matrix_vector_multiply: match");
      end else begin
         $display("matrix_vector_multiply: mismatch");
      end
      $finish;
   end

endmodule
